// File: design/lruocd_pkg.sv
// ----------------------------------------------------------------------------
// LRU object cache directory package
// Request and response payloads, sequencer states and shared codes.
// ----------------------------------------------------------------------------
package lruocd_pkg;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [63:0] key;
      logic [23:0] object_size;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  slot;
      logic [23:0] stored_size;
      logic        evicted;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Write enables of the entry store.
   typedef struct packed {
      logic entry_we;
      logic stamp_we;
   } wr_ctrl_type;

endpackage

// File: design/lru_object_cache_directory_top.sv
// ----------------------------------------------------------------------------
// LRU object cache directory
// Fully associative directory of object entries with least-recently-used
// replacement, scanned one entry per cycle by a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                        Handshake
//   request   start, busy, req_data        taken when start is high, busy low
//   response  rsp_valid, rsp_data          one-cycle strobe, cannot be held off
//
// A request keeps busy high from acceptance through the scan and the finish
// state. The scan is paced by the entry store, whose single read port is
// stepped through the slots one per cycle; a lookup hit or the first empty
// slot of an insert ends the scan early.
// Reset is synchronous and clears the valid bits, the fill count, the tick
// and the sequencer; the key, size and stamp memories need no clearing pass.
// The response is shown for exactly one cycle, and the receiver cannot stall.
//
module lru_object_cache_directory_top #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lruocd_pkg::req_type req_data,
   output logic                rsp_valid,
   output lruocd_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(ENTRIES);

   // Sequencer state.
   lruocd_pkg::state_type state_ff, state_in;

   // The request being worked on is held for the whole scan.
   lruocd_pkg::req_type req_ff, req_in;

   // Read issue counter; it can reach ENTRIES, so the address is a part-select.
   logic [IW:0]   issue_cnt_ff, issue_cnt_in;
   // Follows the issue in the next cycle: which entry the store's read data belongs to.
   logic          ev_live_ff, ev_live_in;
   logic [IW-1:0] ev_idx_ff, ev_idx_in;

   // Running selection: hit slot, empty slot or oldest slot so far.
   logic          sel_found_ff, sel_found_in;
   logic [IW-1:0] sel_idx_ff, sel_idx_in;
   logic [31:0]   sel_stamp_ff, sel_stamp_in;
   logic [23:0]   sel_size_ff, sel_size_in;

   // Directory state kept in flip-flops.
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IW:0]        count_ff, count_in;
   logic [31:0]        tick_ff, tick_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   lruocd_pkg::rsp_type rsp_ff, rsp_in;

   // Sequencer outputs.
   logic accept;
   logic issue_en;
   logic eval_en;
   logic finish_en;

   // Entry store connections.
   lruocd_pkg::wr_ctrl_type wr_ctrl;
   logic [KEY_BITS-1:0]     rd_key;
   logic [23:0]             rd_size;
   logic [31:0]             rd_stamp;

   // Per-entry compare results.
   logic          full;
   logic          key_hit;
   logic          empty_hit;
   logic          older;
   logic          stop;
   logic          scan_done;
   logic [31:0]   tick_next;
   logic [IW+3:0] slot_wide;

   lruocd_entry_store #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_store (
      .clock    (clock),
      .rd_addr  (issue_cnt_ff[IW-1:0]),
      .wr_ctrl  (wr_ctrl),
      .wr_addr  (sel_idx_ff),
      .wr_key   (req_ff.key[KEY_BITS-1:0]),
      .wr_size  (req_ff.object_size),
      .wr_stamp (tick_next),
      .rd_key   (rd_key),
      .rd_size  (rd_size),
      .rd_stamp (rd_stamp)
   );

   // The directory is full only when every slot is valid; eviction then
   // frees the oldest slot, which is also the lowest empty slot to fill.
   assign full      = (count_ff >= (IW + 1)'(ENTRIES));
   assign tick_next = tick_ff + 32'd1;

   // The single compare step applied to one entry per cycle.
   assign key_hit   = valid_ff[ev_idx_ff] && (rd_key == req_ff.key[KEY_BITS-1:0]);
   assign empty_hit = !valid_ff[ev_idx_ff];
   assign older     = (ev_idx_ff == '0) || (rd_stamp < sel_stamp_ff);

   assign stop = (req_ff.kind == lruocd_pkg::KIND_LOOKUP) ? key_hit
                                                          : (!full && empty_hit);
   assign scan_done = ev_live_ff && (stop || (ev_idx_ff == IW'(ENTRIES - 1)));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lruocd_pkg::ST_IDLE: begin
            if (start) state_in = lruocd_pkg::ST_SCAN;
         end
         lruocd_pkg::ST_SCAN: begin
            if (scan_done) state_in = lruocd_pkg::ST_FINISH;
         end
         lruocd_pkg::ST_FINISH: begin
            state_in = lruocd_pkg::ST_IDLE;
         end
         default: begin
            state_in = lruocd_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      busy      = 1'b1;
      accept    = 1'b0;
      issue_en  = 1'b0;
      eval_en   = 1'b0;
      finish_en = 1'b0;
      unique case (state_ff)
         lruocd_pkg::ST_IDLE: begin
            busy   = 1'b0;
            accept = start;
         end
         lruocd_pkg::ST_SCAN: begin
            issue_en = (issue_cnt_ff != (IW + 1)'(ENTRIES));
            eval_en  = ev_live_ff;
         end
         lruocd_pkg::ST_FINISH: begin
            finish_en = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      req_in       = req_ff;
      issue_cnt_in = issue_cnt_ff;
      ev_live_in   = issue_en;
      ev_idx_in    = issue_cnt_ff[IW-1:0];
      sel_found_in = sel_found_ff;
      sel_idx_in   = sel_idx_ff;
      sel_stamp_in = sel_stamp_ff;
      sel_size_in  = sel_size_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      tick_in      = tick_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      wr_ctrl      = '0;
      slot_wide    = {4'd0, sel_idx_ff};

      if (accept) begin
         req_in       = req_data;
         issue_cnt_in = '0;
         sel_found_in = 1'b0;
      end

      if (issue_en) begin
         issue_cnt_in = issue_cnt_ff + (IW + 1)'(1);
      end

      if (eval_en) begin
         if (req_ff.kind == lruocd_pkg::KIND_LOOKUP) begin
            if (key_hit) begin
               sel_found_in = 1'b1;
               sel_idx_in   = ev_idx_ff;
               sel_size_in  = rd_size;
            end
         end else if (full) begin
            if (older) begin
               sel_idx_in   = ev_idx_ff;
               sel_stamp_in = rd_stamp;
            end
         end else if (empty_hit) begin
            sel_found_in = 1'b1;
            sel_idx_in   = ev_idx_ff;
         end
      end

      if (finish_en) begin
         rsp_valid_in = 1'b1;
         if (req_ff.kind == lruocd_pkg::KIND_LOOKUP) begin
            if (sel_found_ff) begin
               tick_in          = tick_next;
               wr_ctrl.stamp_we = 1'b1;
               rsp_in.found       = 1'b1;
               rsp_in.slot        = slot_wide[3:0];
               rsp_in.stored_size = sel_size_ff;
            end
         end else begin
            // An insert into a full directory reuses the evicted slot, so
            // the fill count is unchanged there.
            tick_in              = tick_next;
            wr_ctrl.entry_we     = 1'b1;
            wr_ctrl.stamp_we     = 1'b1;
            valid_in[sel_idx_ff] = 1'b1;
            if (!full) count_in = count_ff + (IW + 1)'(1);
            rsp_in.slot    = slot_wide[3:0];
            rsp_in.evicted = full;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lruocd_pkg::ST_IDLE;
         ev_live_ff   <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ev_live_ff   <= ev_live_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      issue_cnt_ff <= issue_cnt_in;
      ev_idx_ff    <= ev_idx_in;
      sel_found_ff <= sel_found_in;
      sel_idx_ff   <= sel_idx_in;
      sel_stamp_ff <= sel_stamp_in;
      sel_size_ff  <= sel_size_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/lruocd_entry_store.sv
// ----------------------------------------------------------------------------
// LRU object cache directory entry store
// Key, size and stamp memories with one write port and one registered read.
// ----------------------------------------------------------------------------
module lruocd_entry_store #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 64
) (
   input  logic                       clock,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   input  lruocd_pkg::wr_ctrl_type    wr_ctrl,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [KEY_BITS-1:0]        wr_key,
   input  logic [23:0]                wr_size,
   input  logic [31:0]                wr_stamp,
   output logic [KEY_BITS-1:0]        rd_key,
   output logic [23:0]                rd_size,
   output logic [31:0]                rd_stamp
);

   logic [KEY_BITS-1:0] key_mem   [ENTRIES];
   logic [23:0]         size_mem  [ENTRIES];
   logic [31:0]         stamp_mem [ENTRIES];

   logic [KEY_BITS-1:0] rd_key_ff;
   logic [23:0]         rd_size_ff;
   logic [31:0]         rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (wr_ctrl.entry_we) begin
         key_mem[wr_addr]  <= wr_key;
         size_mem[wr_addr] <= wr_size;
      end
      if (wr_ctrl.stamp_we) begin
         stamp_mem[wr_addr] <= wr_stamp;
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem[rd_addr];
      rd_size_ff  <= size_mem[rd_addr];
      rd_stamp_ff <= stamp_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_size  = rd_size_ff;
   assign rd_stamp = rd_stamp_ff;

endmodule

// File: design/lruocd_checker.sv
// ----------------------------------------------------------------------------
// LRU object cache directory checker
// Port-level properties of the request sequencer and the response strobe.
// ----------------------------------------------------------------------------
module lruocd_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input lruocd_pkg::req_type req_data,
   input logic                rsp_valid,
   input lruocd_pkg::rsp_type rsp_data
);

   // An accepted request keeps the block busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // Every request ends with its response in the cycle busy drops.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response");

   // A response is a single-cycle strobe.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   // A hit never evicts, and a miss or an insert reports no stored size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!(rsp_data.found && rsp_data.evicted)
                     && (rsp_data.found || (rsp_data.stored_size == 24'd0))))
      else $error("inconsistent response fields");

endmodule

bind lru_object_cache_directory_top lruocd_checker u_lruocd_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// File: sim/tb_lru_object_cache_directory_top.sv
// ----------------------------------------------------------------------------
// LRU object cache directory testbench
// Drives lookups and inserts through the start/busy command port, predicts
// each response with a cycle-free model of the directory, and compares every
// response strobe field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_lru_object_cache_directory_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          ENTRIES    = 16;
   localparam int          KEY_BITS   = 64;
   localparam int          TAIL_CYC   = 40;      // room for any stray strobe at the end
   localparam int unsigned CYCLE_CAP  = 300000;  // far beyond the slowest legal run
   localparam int          POOL_DEPTH = 24;      // recent keys kept for hits

   // One request waiting in the driver's queue, with the idle rate of its
   // phase and whether the driver must drain all responses before sending it.
   typedef struct {
      lruocd_pkg::req_type req;
      int unsigned         idle_pct;
      bit                  drain;
   } pending_req_type;

   logic                clock    = 1'b0;
   logic                reset    = 1'b1;
   logic                start    = 1'b0;
   lruocd_pkg::req_type req_data = '0;
   logic                busy;
   logic                rsp_valid;
   lruocd_pkg::rsp_type rsp_data;

   pending_req_type     pending_q[$];
   lruocd_pkg::rsp_type directory_rsp_q[$];
   logic [63:0]         key_pool[$];

   int unsigned accepted_cnt = 0;
   int unsigned issued_cnt   = 0;
   int unsigned gap_left     = 0;
   int unsigned cur_idle_pct = 0;
   int unsigned mismatch_cnt = 0;
   int unsigned cycle_cnt    = 0;
   int unsigned hit_cnt      = 0;
   int unsigned evict_cnt    = 0;
   int unsigned insert_cnt   = 0;

   // Shadow copy of the directory, advanced once per accepted request.
   logic        dir_valid [ENTRIES];
   logic [63:0] dir_key   [ENTRIES];
   logic [23:0] dir_size  [ENTRIES];
   logic [31:0] dir_stamp [ENTRIES];
   logic [31:0] dir_tick;
   int unsigned dir_count;

   lru_object_cache_directory_top #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Applies one request to the shadow directory and returns the response the
   // block must give for it. A lookup scans for the lowest valid matching slot
   // and only bumps the tick on a hit. An insert always bumps the tick, evicts
   // the slot with the smallest stamp when the directory is full (the strict
   // less-than keeps ties on the lowest index), and fills the lowest hole.
   function automatic lruocd_pkg::rsp_type directory_access(lruocd_pkg::req_type r);
      lruocd_pkg::rsp_type res;
      bit                  hit;
      int                  victim;
      int                  hole;
      res = '0;
      if (r.kind == lruocd_pkg::KIND_LOOKUP) begin
         hit = 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (!hit && dir_valid[i] && dir_key[i] == r.key) begin
               hit             = 1'b1;
               dir_tick        = dir_tick + 32'd1;
               dir_stamp[i]    = dir_tick;
               res.found       = 1'b1;
               res.slot        = 4'(i);
               res.stored_size = dir_size[i];
            end
         end
      end else begin
         dir_tick = dir_tick + 32'd1;
         if (dir_count >= ENTRIES) begin
            victim = 0;
            for (int i = 1; i < ENTRIES; i++) begin
               if (dir_stamp[i] < dir_stamp[victim]) victim = i;
            end
            if (dir_valid[victim] && dir_count > 0) dir_count--;
            dir_valid[victim] = 1'b0;
            dir_key[victim]   = '0;
            dir_size[victim]  = '0;
            dir_stamp[victim] = '0;
            res.evicted       = 1'b1;
         end
         hole = -1;
         for (int i = 0; i < ENTRIES; i++) begin
            if (hole < 0 && !dir_valid[i]) hole = i;
         end
         // With a hole guaranteed after eviction, the fall-through that would
         // leave slot 0 and fill nothing is never taken here.
         if (hole >= 0) begin
            dir_valid[hole] = 1'b1;
            dir_key[hole]   = r.key;
            dir_size[hole]  = r.object_size;
            dir_stamp[hole] = dir_tick;
            dir_count++;
            res.slot        = 4'(hole);
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] rand_key();
      return {$urandom(), $urandom()};
   endfunction

   // Sizes favor the two extremes now and then; otherwise any 24-bit value.
   function automatic logic [23:0] rand_size();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8) return 24'h000000;
      if (pick < 16) return 24'hFFFFFF;
      return 24'($urandom());
   endfunction

   task automatic add_req(logic kind, logic [63:0] key, logic [23:0] size,
                          int unsigned idle_pct, bit drain);
      pending_req_type p;
      p.req.kind        = kind;
      p.req.key         = key;
      p.req.object_size = size;
      p.idle_pct        = idle_pct;
      p.drain           = drain;
      pending_q.push_back(p);
      if (kind == lruocd_pkg::KIND_INSERT) begin
         key_pool.push_back(key);
         if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
      end
   endtask

   // Driver. Inputs only change on the falling edge, so the block sees them
   // stable at every rising edge. A request is held until the monitor has
   // counted its acceptance. Right after an acceptance the driver may take a
   // random gap, which lands the next start anywhere from early in the scan to
   // well after busy has dropped.
   always @(negedge clock) begin
      if (!reset) begin
         if (!(start && accepted_cnt != issued_cnt)) begin
            if (start && $urandom_range(99) < cur_idle_pct) begin
               gap_left = $urandom_range(30, 1);
            end
            if (gap_left != 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (pending_q[0].drain && directory_rsp_q.size() != 0)) begin
               // Nothing left to send, or this request waits for the
               // directory to go quiet before it may be issued.
               start <= 1'b0;
            end else begin
               req_data     <= pending_q[0].req;
               start        <= 1'b1;
               cur_idle_pct  = pending_q[0].idle_pct;
               issued_cnt++;
               void'(pending_q.pop_front());
            end
         end
      end
   end

   // Monitor. Everything is sampled at the rising edge. A response is checked
   // before a request accepted at the same edge is predicted, so the oldest
   // prediction is always the one that the strobe answers.
   always @(posedge clock) begin
      lruocd_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (directory_rsp_q.size() == 0) begin
               $error("response strobe with no request outstanding");
               mismatch_cnt++;
            end else begin
               want = directory_rsp_q.pop_front();
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_data.found);
                  mismatch_cnt++;
               end
               if (rsp_data.slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_data.slot);
                  mismatch_cnt++;
               end
               if (rsp_data.stored_size !== want.stored_size) begin
                  $error("stored_size: expected 0x%06h, got 0x%06h",
                         want.stored_size, rsp_data.stored_size);
                  mismatch_cnt++;
               end
               if (rsp_data.evicted !== want.evicted) begin
                  $error("evicted: expected %0d, got %0d", want.evicted, rsp_data.evicted);
                  mismatch_cnt++;
               end
            end
         end
         if (start && !busy) begin
            want = directory_access(req_data);
            directory_rsp_q.push_back(want);
            accepted_cnt <= accepted_cnt + 1;
            if (want.found) hit_cnt++;
            if (want.evicted) evict_cnt++;
            if (req_data.kind == lruocd_pkg::KIND_INSERT) insert_cnt++;
         end
      end
   end

   // Watchdog on the whole run; a hung handshake ends here.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("lru_object_cache_directory_top regression: fail");
         $finish;
      end
   end

   initial begin
      int unsigned phase_idle [3];
      int unsigned pick;
      logic [63:0] k;

      for (int i = 0; i < ENTRIES; i++) begin
         dir_valid[i] = 1'b0;
         dir_key[i]   = '0;
         dir_size[i]  = '0;
         dir_stamp[i] = '0;
      end
      dir_tick  = '0;
      dir_count = 0;

      // Directed opening. Lookups on the empty directory must miss, the two
      // extreme keys and sizes go in, a duplicate insert must leave lookups
      // on the lower copy, a key one bit away must miss, and filling all
      // sixteen slots forces an eviction of the least recently used entry.
      add_req(lruocd_pkg::KIND_LOOKUP, 64'h0, 24'h0, 0, 1'b0);
      add_req(lruocd_pkg::KIND_LOOKUP, '1, 24'hFFFFFF, 0, 1'b0);
      add_req(lruocd_pkg::KIND_INSERT, 64'h0, 24'h000000, 0, 1'b0);
      add_req(lruocd_pkg::KIND_INSERT, '1, 24'hFFFFFF, 0, 1'b0);
      add_req(lruocd_pkg::KIND_LOOKUP, 64'h0, 24'hFFFFFF, 0, 1'b0);
      add_req(lruocd_pkg::KIND_LOOKUP, '1, 24'h0, 0, 1'b0);
      add_req(lruocd_pkg::KIND_INSERT, '1, 24'h123456, 0, 1'b0);
      add_req(lruocd_pkg::KIND_LOOKUP, '1, 24'h0, 0, 1'b0);
      add_req(lruocd_pkg::KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 24'h0, 0, 1'b0);
      for (int i = 0; i < 13; i++) begin
         add_req(lruocd_pkg::KIND_INSERT, rand_key(), rand_size(), 0, 1'b0);
      end
      add_req(lruocd_pkg::KIND_INSERT, rand_key(), rand_size(), 0, 1'b0);
      add_req(lruocd_pkg::KIND_LOOKUP, 64'h0, 24'h0, 0, 1'b0);
      add_req(lruocd_pkg::KIND_LOOKUP, '1, 24'h0, 0, 1'b0);

      // Random phases: back to back, a sender idle most of the time, and a
      // sender idle now and then. Each phase opens after a full drain, and
      // every phase drains once more halfway through.
      phase_idle[0] = 0;
      phase_idle[1] = 58;
      phase_idle[2] = 11;
      for (int ph = 0; ph < 3; ph++) begin
         for (int n = 0; n < 145; n++) begin
            pick = $urandom_range(99);
            if (pick < 38) begin
               // Recently inserted keys, so most of these are hits unless
               // the entry has aged out.
               k = key_pool[$urandom_range(key_pool.size() - 1)];
               add_req(lruocd_pkg::KIND_LOOKUP, k, rand_size(), phase_idle[ph],
                       n == 0 || n == 72);
            end else if (pick < 48) begin
               k = key_pool[$urandom_range(key_pool.size() - 1)] ^
                   (64'd1 << $urandom_range(63));
               add_req(lruocd_pkg::KIND_LOOKUP, k, rand_size(), phase_idle[ph],
                       n == 0 || n == 72);
            end else if (pick < 56) begin
               add_req(lruocd_pkg::KIND_LOOKUP, rand_key(), rand_size(), phase_idle[ph],
                       n == 0 || n == 72);
            end else if (pick < 84) begin
               add_req(lruocd_pkg::KIND_INSERT, rand_key(), rand_size(), phase_idle[ph],
                       n == 0 || n == 72);
            end else if (pick < 94) begin
               // Duplicate of a recently inserted key: a later lookup must still find the
               // lower slot.
               k = key_pool[$urandom_range(key_pool.size() - 1)];
               add_req(lruocd_pkg::KIND_INSERT, k, rand_size(), phase_idle[ph],
                       n == 0 || n == 72);
            end else begin
               add_req(lruocd_pkg::KIND_INSERT, 64'($urandom_range(7)), rand_size(),
                       phase_idle[ph], n == 0 || n == 72);
            end
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every request has gone out and every response has come
      // back, then leave room for any stray strobe before judging the run.
      @(negedge clock);
      while (pending_q.size() != 0 || start || directory_rsp_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_CYC) @(posedge clock);

      $display("%0d requests accepted (%0d inserts, %0d lookups) in %0d cycles",
               accepted_cnt, insert_cnt, accepted_cnt - insert_cnt, cycle_cnt);
      $display("%0d lookup hits and %0d LRU evictions predicted and compared",
               hit_cnt, evict_cnt);
      if (mismatch_cnt == 0) begin
         $display("lru_object_cache_directory_top regression: pass");
      end else begin
         $display("lru_object_cache_directory_top regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
design/lruocd_pkg.sv
design/lruocd_entry_store.sv
design/lru_object_cache_directory_top.sv
design/lruocd_checker.sv
sim/tb_lru_object_cache_directory_top.sv
